>>> hw/rtl/signed_int_to_ascii_radix_macros.svh
// assertion macros used by the checker of the integer to text block
// no dependencies; every macro samples on clk and is disabled while rst is high
`ifndef SIGNED_INT_TO_ASCII_RADIX_MACROS_SVH
`define SIGNED_INT_TO_ASCII_RADIX_MACROS_SVH

// condition in one cycle implies consequence in the same cycle
`define S2A_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("s2a assertion failed (same cycle)");

// condition in one cycle implies consequence in the next cycle
`define S2A_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("s2a assertion failed (next cycle)");

`endif

>>> hw/rtl/s2a_pkg.sv
// shared constants and helpers for the signed integer to ascii text block
// no dependencies
`timescale 1ns / 1ps

package s2a_pkg;

  localparam int WORD_W     = 32;             // width of the input value
  localparam int NIB_W      = 4;              // one decimal or hex digit
  localparam int DEC_DIGITS = 10;             // 32-bit magnitude fits ten decimal digits
  localparam int HEX_DIGITS = WORD_W / NIB_W; // eight hex digits
  localparam int BCD_W      = DEC_DIGITS * NIB_W;
  localparam int REM_W      = 4;              // digit counter, holds up to ten
  localparam int CNT_W      = 5;              // bit counter of the conversion
  localparam int CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOW_F = 8'h66;

  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  // ascii glyph of one digit, lower-case letters above nine
  function automatic logic [CHAR_W-1:0] glyph(input logic [NIB_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-NIB_W){1'b0}}, d};
    if (d < 4'd10) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_LOW_A - 8'd10 + ext;
    end
  endfunction

endpackage

>>> hw/rtl/s2a_if.sv
// valid/ready channel interfaces for the input item and the output character
// depends on s2a_pkg for the field widths
`timescale 1ns / 1ps

interface s2a_item_if;
  logic                              valid;
  logic                              ready;
  logic signed [s2a_pkg::WORD_W-1:0] value;
  logic                              op;

  modport source(output valid, output value, output op, input ready);
  modport sink(input valid, input value, input op, output ready);
endinterface

interface s2a_text_if;
  logic                       valid;
  logic                       ready;
  logic [s2a_pkg::CHAR_W-1:0] char_code;
  logic                       is_last;

  modport source(output valid, output char_code, output is_last, input ready);
  modport sink(input valid, input char_code, input is_last, output ready);
endinterface

>>> hw/rtl/s2a_dabble.sv
// bit-serial binary to bcd conversion (shift and add three), one bit per cycle
// depends on s2a_pkg
`timescale 1ns / 1ps

module s2a_dabble (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [s2a_pkg::WORD_W-1:0]    mag,
  output logic                          done,
  output logic [s2a_pkg::BCD_W-1:0]     bcd
);

  logic [s2a_pkg::WORD_W-1:0] bin;
  logic [s2a_pkg::CNT_W-1:0]  cnt;
  logic                       busy;
  logic [s2a_pkg::BCD_W-1:0]  adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < s2a_pkg::DEC_DIGITS; i++) begin
      if (bcd[i*s2a_pkg::NIB_W +: s2a_pkg::NIB_W] >= 4'd5) begin
        adj[i*s2a_pkg::NIB_W +: s2a_pkg::NIB_W] =
          bcd[i*s2a_pkg::NIB_W +: s2a_pkg::NIB_W] + 4'd3;
      end else begin
        adj[i*s2a_pkg::NIB_W +: s2a_pkg::NIB_W] =
          bcd[i*s2a_pkg::NIB_W +: s2a_pkg::NIB_W];
      end
    end
  end

  // control: bit counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == s2a_pkg::CNT_W'(s2a_pkg::WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: binary shifts out msb first into the bcd register
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (busy) begin
      bin <= {bin[s2a_pkg::WORD_W-2:0], 1'b0};
      bcd <= {adj[s2a_pkg::BCD_W-2:0], bin[s2a_pkg::WORD_W-1]};
    end
  end

endmodule

>>> hw/rtl/signed_int_to_ascii_radix.sv
// top level: signed 32-bit integer to ascii text, decimal or lower-case hex
// depends on s2a_pkg, s2a_if (channel interfaces) and s2a_dabble
//
// usage:
//   item channel takes value (signed 32 bits) and op (0 decimal, 1 hex).
//   text channel gives one ascii character per transfer, most significant
//   first: '-' for a negative value, then the digits of the magnitude;
//   is_last marks the final character of the number.
// sequence:
//   one number at a time; item.ready is high only while idle.
//   decimal: bit-serial conversion in s2a_dabble, then leading zeros are
//   dropped one at a time (up to nine), then '-' for a negative value, then
//   one character per digit; the next item transfers once the last
//   character has entered the output register.
//   hex needs no conversion: leading zeros (up to seven) are dropped, then
//   the sign and the digits follow as for decimal.
// reset: rst clears the control state; no transfer is pending afterwards.
// stall: a character waits in the output register while text.ready is low;
//   the block holds its digits and resumes when the transfer completes.
`timescale 1ns / 1ps

module signed_int_to_ascii_radix (
  input  logic        clk,
  input  logic        rst,
  s2a_item_if.sink    item,
  s2a_text_if.source  text
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                          state;
  logic                            neg;
  logic [s2a_pkg::BCD_W-1:0]       digits;
  logic [s2a_pkg::REM_W-1:0]       rem;
  logic [s2a_pkg::WORD_W-1:0]      raw;
  logic [s2a_pkg::WORD_W-1:0]      mag;
  logic [s2a_pkg::NIB_W-1:0]       top_nib;
  logic                            accept;
  logic                            slot_free;
  logic                            dab_start;
  logic                            dab_done;
  logic [s2a_pkg::BCD_W-1:0]       dab_bcd;
  logic                            out_valid;
  logic [s2a_pkg::CHAR_W-1:0]      out_char;
  logic                            out_last;

  // input transfer and magnitude
  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign raw        = item.value;
  assign mag        = raw[s2a_pkg::WORD_W-1] ? (~raw + 1'b1) : raw;
  assign dab_start  = accept && (item.op == s2a_pkg::OP_DEC);
  assign top_nib    = digits[s2a_pkg::BCD_W-1 -: s2a_pkg::NIB_W];
  assign slot_free  = !out_valid || text.ready;

  s2a_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (dab_start),
    .mag   (mag),
    .done  (dab_done),
    .bcd   (dab_bcd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (item.op == s2a_pkg::OP_HEX) ? ST_SKIP : ST_CONV;
          end
        end
        ST_CONV: begin
          if (dab_done) begin
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (!(top_nib == '0 && rem > 4'd1)) begin
            state <= neg ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free && rem == 4'd1) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // digit register: loaded on transfer, reloaded with bcd if decimal, shifted one digit per cycle unless stalled
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          neg    <= raw[s2a_pkg::WORD_W-1];
          digits <= {mag, {(s2a_pkg::BCD_W - s2a_pkg::WORD_W){1'b0}}};
          rem    <= s2a_pkg::REM_W'(s2a_pkg::HEX_DIGITS);
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          digits <= dab_bcd;
          rem    <= s2a_pkg::REM_W'(s2a_pkg::DEC_DIGITS);
        end
      end
      ST_SKIP: begin
        if (top_nib == '0 && rem > 4'd1) begin
          digits <= {digits[s2a_pkg::BCD_W-s2a_pkg::NIB_W-1:0], {s2a_pkg::NIB_W{1'b0}}};
          rem    <= rem - 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          digits <= {digits[s2a_pkg::BCD_W-s2a_pkg::NIB_W-1:0], {s2a_pkg::NIB_W{1'b0}}};
          rem    <= rem - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_SIGN || state == ST_EMIT) && slot_free) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register: character payload
  always_ff @(posedge clk) begin
    if (state == ST_SIGN && slot_free) begin
      out_char <= s2a_pkg::CHAR_MINUS;
      out_last <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_char <= s2a_pkg::glyph(top_nib);
      out_last <= (rem == 4'd1);
    end
  end

  assign text.valid     = out_valid;
  assign text.char_code = out_char;
  assign text.is_last   = out_last;

endmodule

>>> hw/rtl/s2a_checker.sv
// port-level checker for the integer to text block, bound to the top level
// depends on s2a_pkg and signed_int_to_ascii_radix_macros.svh
`timescale 1ns / 1ps
`include "signed_int_to_ascii_radix_macros.svh"

module s2a_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic                       text_valid,
  input logic                       text_ready,
  input logic [s2a_pkg::CHAR_W-1:0] text_char,
  input logic                       text_last
);

  logic                       char_ok;
  logic [s2a_pkg::CHAR_W:0]   text_out;

  // legal glyphs: minus, decimal digits, lower-case hex letters
  assign char_ok = (text_char == s2a_pkg::CHAR_MINUS)
                || (text_char >= s2a_pkg::CHAR_ZERO && text_char <= s2a_pkg::CHAR_NINE)
                || (text_char >= s2a_pkg::CHAR_LOW_A && text_char <= s2a_pkg::CHAR_LOW_F);

  // whole payload of the text channel
  assign text_out = {text_char, text_last};

  // a stalled character holds
  `S2A_ASSERT_NEXT(a_hold, text_valid && !text_ready, text_valid && $stable(text_out))

  // one number at a time: busy right after an item transfer
  `S2A_ASSERT_NEXT(a_busy_after_take, item_valid && item_ready, !item_ready)

  // a pending character that is not the last means the number is unfinished
  `S2A_ASSERT_NOW(a_busy_mid_number, text_valid && !text_last, !item_ready)

  // only glyphs of the two radixes and the sign leave
  `S2A_ASSERT_NOW(a_glyph, text_valid, char_ok)

endmodule

bind signed_int_to_ascii_radix s2a_checker u_s2a_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .text_valid (text.valid),
  .text_ready (text.ready),
  .text_char  (text.char_code),
  .text_last  (text.is_last)
);

>>> bench/tb.sv
// self-checking bench for signed_int_to_ascii_radix: numbers in, ascii text out
// depends on s2a_pkg, s2a_if and the rtl of the block; predicts every character
`timescale 1ns / 1ps

module tb;

  localparam int RANDOM_ITEMS   = 80;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 64;

  // expected text of every accepted number, one entry per character
  class text_scoreboard;
    typedef struct packed {
      logic [s2a_pkg::CHAR_W-1:0] char_code;
      logic                       is_last;
    } text_char_t;

    text_char_t expected_text[$];
    int errors;
    int numbers;
    int hex_numbers;
    int negatives;
    int chars;

    function new();
      errors      = 0;
      numbers     = 0;
      hex_numbers = 0;
      negatives   = 0;
      chars       = 0;
    endfunction

    function int pending();
      return expected_text.size();
    endfunction

    // work out the text of one accepted number
    function void note_number(logic signed [s2a_pkg::WORD_W-1:0] value, logic op);
      logic [s2a_pkg::WORD_W-1:0] mag;
      logic [s2a_pkg::WORD_W-1:0] base;
      logic [s2a_pkg::CHAR_W-1:0] rev[s2a_pkg::DEC_DIGITS];
      string                      glyphs;
      int                         ndig;
      int                         i;
      glyphs = "0123456789abcdef";
      base = (op == s2a_pkg::OP_HEX) ? 32'd16 : 32'd10;
      mag  = value[s2a_pkg::WORD_W-1] ? (32'd0 - value) : value;
      ndig = 0;
      // digits least significant first; the magnitude of the most negative
      // value still fits the unsigned word
      do begin
        rev[ndig] = glyphs[int'(mag % base)];
        ndig++;
        mag = mag / base;
      end while (mag != 0 && ndig < s2a_pkg::DEC_DIGITS);
      if (value[s2a_pkg::WORD_W-1]) begin
        expected_text.push_back('{s2a_pkg::CHAR_MINUS, 1'b0});
        negatives++;
      end
      for (i = ndig - 1; i >= 0; i--) begin
        expected_text.push_back('{rev[i], (i == 0)});
      end
      numbers++;
      if (op == s2a_pkg::OP_HEX) begin
        hex_numbers++;
      end
    endfunction

    // compare one transferred character with the oldest expectation
    function void check_char(logic [s2a_pkg::CHAR_W-1:0] char_code, logic is_last);
      text_char_t exp;
      chars++;
      if (expected_text.size() == 0) begin
        $error("unexpected character: char_code %h is_last %b", char_code, is_last);
        errors++;
        return;
      end
      exp = expected_text.pop_front();
      if (char_code !== exp.char_code) begin
        $error("char_code mismatch: expected %h, actual %h", exp.char_code, char_code);
        errors++;
      end
      if (is_last !== exp.is_last) begin
        $error("is_last mismatch: expected %b, actual %b", exp.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hold_req;
  logic no_stall;
  int   idle_cycles;

  s2a_item_if item_ch ();
  s2a_text_if text_ch ();

  text_scoreboard sb = new();

  signed_int_to_ascii_radix dut (
    .clk  (clk),
    .rst  (rst),
    .item (item_ch),
    .text (text_ch)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // gap before an item or a stall length: mostly short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // random value with weight on small numbers and digit-count boundaries
  function automatic logic signed [s2a_pkg::WORD_W-1:0] pick_value();
    logic signed [s2a_pkg::WORD_W-1:0] v;
    logic [s2a_pkg::WORD_W-1:0]        p;
    int                                sel;
    sel = $urandom_range(0, 4);
    case (sel) inside
      [0:1]: v = $urandom;
      2: v = $urandom_range(0, 20);
      3: v = $urandom_range(0, 99999);
      default: begin
        p = 1;
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(0, 9)) p = p * 10;
        end else begin
          p = p << (4 * $urandom_range(0, 7));
        end
        v = p - $urandom_range(0, 1);
      end
    endcase
    if (sel >= 2 && $urandom_range(0, 1)) begin
      v = -v;
    end
    return v;
  endfunction

  // offer one number and wait for its transfer
  task automatic send_number(input logic signed [s2a_pkg::WORD_W-1:0] v, input logic op,
                             input int gap);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.value <= v;
    item_ch.op    <= op;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_number(v, op);
  endtask

  // receiver: random back-pressure, one long hold on request
  initial begin
    int stall_left;
    int roll;
    bit hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    text_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && text_ch.valid && text_ch.ready) begin
        sb.check_char(text_ch.char_code, text_ch.is_last);
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        text_ch.ready <= 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (no_stall || roll < 65) begin
          text_ch.ready <= 1'b1;
        end else begin
          text_ch.ready <= 1'b0;
          stall_left = pick_gap();
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (text_ch.valid && text_ch.ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d characters outstanding",
               idle_cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic signed [s2a_pkg::WORD_W-1:0] directed_values[12];
    int                                i;
    int                                n;
    int                                gap;
    directed_values = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd15,
                        32'sd16, 32'sh7fffffff, 32'sh80000000, 32'sd1000000000,
                        -32'sd999999999};
    rst           <= 1'b1;
    hold_req      <= 1'b0;
    no_stall      <= 1'b0;
    item_ch.valid <= 1'b0;
    item_ch.value <= '0;
    item_ch.op    <= s2a_pkg::OP_DEC;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: zero, single digits, digit-count boundaries, both extremes, each radix
    for (i = 0; i < 12; i++) begin
      send_number(directed_values[i], s2a_pkg::OP_DEC, pick_gap());
      send_number(directed_values[i], s2a_pkg::OP_HEX, pick_gap());
    end

    // random numbers, with a long receiver hold, a burst and a full drain
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 30) begin
        hold_req <= 1'b1;
      end
      no_stall <= (n >= 50 && n < 65);
      if (n == 75) begin
        // let every outstanding character leave before going on
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        gap = 0;
      end else if ((n >= 30 && n < 40) || (n >= 50 && n < 65)) begin
        gap = 0;
      end else begin
        gap = pick_gap();
      end
      send_number(pick_value(), $urandom_range(0, 1) ? s2a_pkg::OP_HEX : s2a_pkg::OP_DEC,
                  gap);
    end
    item_ch.valid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d numbers (%0d hex, %0d negative) into %0d characters",
             sb.numbers, sb.hex_numbers, sb.negatives, sb.chars);
    $display("back-pressure covered random stalls, a %0d-cycle hold and a full drain",
             LONG_HOLD);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
